// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the queue block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("queue check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("queue check failed");

`endif

// ===== hw/rtl/dq_pkg.sv =====
// Shared types, sizes and ring helper for the double-ended queue.
package dq_pkg;

  localparam int DEPTH  = 16;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int REQ_W  = 3;
  localparam int OUT_CW = 5;
  localparam int ST_W   = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_FRONT = 3'd4,
    REQ_PEEK_BACK  = 3'd5
  } req_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  // Position base+off, wrapped at DEPTH; off <= DEPTH is not enforced.
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

endpackage

// ===== hw/rtl/double_ended_queue.sv =====
// Double-ended queue top level: controller plus datapath.
// A request accepted at one edge is executed in the next cycle (slot memory
// access and ring update); its result strobes on out_valid in the cycle after.
// A new request can be taken while a result shows, but not while one executes.
// Synchronous active-low reset empties the queue; slot contents are not cleared.
module double_ended_queue (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [dq_pkg::REQ_W-1:0]         in_req_type,
  input  logic signed [dq_pkg::DATA_W-1:0] in_value,
  output logic                             out_valid,
  output logic signed [dq_pkg::DATA_W-1:0] out_data,
  output logic [dq_pkg::OUT_CW-1:0]        out_count,
  output logic [dq_pkg::ST_W-1:0]          out_status
);
  import dq_pkg::*;

  cmd_t cmd;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  dq_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_req_type (in_req_type),
    .in_value    (in_value),
    .out_data    (out_data),
    .out_count   (out_count),
    .out_status  (out_status)
  );

endmodule

// ===== hw/rtl/dq_ctrl.sv =====
// Controller state machine that sequences one request at a time.
module dq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          out_valid,
  output dq_pkg::cmd_t  cmd
);
  import dq_pkg::*;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands. A new request may enter while a result shows.
  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.exec  = 1'b0;
    busy      = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        busy      = 1'b1;
        cmd.exec  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/dq_dpath.sv =====
// Datapath: slot memory, front index, entry count and result registers.
module dq_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dq_pkg::cmd_t                     cmd,
  input  logic [dq_pkg::REQ_W-1:0]         in_req_type,
  input  logic signed [dq_pkg::DATA_W-1:0] in_value,
  output logic signed [dq_pkg::DATA_W-1:0] out_data,
  output logic [dq_pkg::OUT_CW-1:0]        out_count,
  output logic [dq_pkg::ST_W-1:0]          out_status
);
  import dq_pkg::*;

  logic [DATA_W-1:0] slots [DEPTH];

  logic [REQ_W-1:0]  req_r;
  logic [DATA_W-1:0] val_r;
  logic [AW-1:0]     front_r, front_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [DATA_W-1:0] rd_data_r;
  logic              sel_r;
  logic [ST_W-1:0]   status_r, status_nxt;

  logic              is_full, is_empty;
  logic [CW-1:0]     ring_off;
  logic [AW-1:0]     ring_addr;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;

  // Request capture on acceptance.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      val_r <= in_value;
    end
  end

  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);

  // One shared ring adder: offset from the front for the back end or front + 1.
  always_comb begin
    case (req_r)
      REQ_PUSH_BACK:  ring_off = count_r;
      REQ_POP_FRONT:  ring_off = CW'(1);
      REQ_POP_BACK,
      REQ_PEEK_BACK:  ring_off = count_r - CW'(1);
      default:        ring_off = '0;
    endcase
  end

  assign ring_addr = ring_pos(front_r, ring_off);

  // Decode of the request against the current fill level.
  always_comb begin
    front_nxt  = front_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    wr_addr    = ring_addr;
    rd_addr    = ring_addr;
    case (req_r)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
          if (req_r == REQ_PUSH_FRONT) begin
            front_nxt = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
            wr_addr   = front_nxt;
          end
        end
      end
      REQ_POP_FRONT, REQ_PEEK_FRONT, REQ_POP_BACK, REQ_PEEK_BACK: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_en = 1'b1;
          if (req_r == REQ_POP_FRONT || req_r == REQ_PEEK_FRONT) begin
            rd_addr = front_r;
          end
          if (req_r == REQ_POP_FRONT) begin
            front_nxt = ring_addr;
          end
          if (req_r == REQ_POP_FRONT || req_r == REQ_POP_BACK) begin
            count_nxt = count_r - CW'(1);
          end
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // Slot memory with registered read.
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      slots[wr_addr] <= val_r;
    end
    if (cmd.exec && rd_en) begin
      rd_data_r <= slots[rd_addr];
    end
  end

  // Ring state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      sel_r    <= rd_en;
      status_r <= status_nxt;
    end
  end

  assign out_data   = sel_r ? rd_data_r : '0;
  assign out_count  = OUT_CW'(count_r);
  assign out_status = status_r;

endmodule

// ===== hw/rtl/dq_checker.sv =====
// Port-level checker for the double-ended queue and its bind.
`include "assert_macros.svh"

module dq_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             out_valid,
  input logic signed [dq_pkg::DATA_W-1:0] out_data,
  input logic [dq_pkg::OUT_CW-1:0]        out_count,
  input logic [dq_pkg::ST_W-1:0]          out_status
);
  import dq_pkg::*;

  logic accept;
  assign accept = start && !busy;

  // Every accepted request passes through the execute state and then produces its result on out_valid.
  `DQ_ASSERT_IMP(a_result_follows, clk, rst_n, accept, ##2 out_valid)

  // The block is busy in the cycle after it accepts a request.
  `DQ_ASSERT_NXT(a_busy_after_accept, clk, rst_n, accept, busy)

  // A full rejection reports a full queue and no data.
  `DQ_ASSERT_IMP(a_full_status, clk, rst_n, out_valid && out_status == ST_FULL,
                 out_count == OUT_CW'(DEPTH) && out_data == '0)

  // An empty rejection reports an empty queue and no data.
  `DQ_ASSERT_IMP(a_empty_status, clk, rst_n, out_valid && out_status == ST_EMPTY,
                 out_count == '0 && out_data == '0)

  // The count never exceeds the capacity.
  `DQ_ASSERT_IMP(a_count_bound, clk, rst_n, out_valid, out_count <= OUT_CW'(DEPTH))

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);
